// File: hw/rtl/sfr_pkg.sv
// Shared types and codes for the serial frame receiver.
// Item structs, operation/status/register codes, controller-datapath buses.
// No dependencies.
package sfr_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_LINE_ERR = 3'd2;
  localparam logic [2:0] ST_BAD_ARG  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_FORMAT   = 3'd5;
  localparam logic [2:0] ST_TOO_LONG = 3'd6;
  localparam logic [2:0] ST_CHECKSUM = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER   = 2'd0;
  localparam logic [1:0] CFG_TAIL     = 2'd1;
  localparam logic [1:0] CFG_IDLE_GAP = 2'd2;

  localparam logic [7:0] HEADER_RST   = 8'd170;
  localparam logic [7:0] TAIL_RST     = 8'd85;
  localparam logic [7:0] IDLE_GAP_RST = 8'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        line_error;
    logic [31:0] limit_ticks;
  } sfr_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] address;
    logic [7:0] function_code;
    logic [5:0] pay_len;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       byte_valid;
    logic       last;
  } sfr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;        // consume the buffered item and update receive state
    logic load_evt;    // load the item's single result
    logic scan_rd;     // read the next stored byte for the frame check
    logic load_final;  // load the frame check's single result
    logic emit_rd;     // read the next payload byte
    logic emit_load;   // load one payload result
  } sfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic buf_valid;
    logic out_free;
    logic evt_res;
    logic evt_check;
    logic ptr_last;
    logic final_multi;
    logic emit_last;
  } sfr_sts_t;

endpackage

// File: hw/rtl/serial_frame_receiver_unit.sv
// Top level of the serial frame receiver: controller plus datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_datapath (and sfr_ram below it).
//
// Receives header/tail framed bytes with an 8-bit additive checksum. Items
// are start, byte and millisecond tick; an item is taken into a one-entry
// buffer, so a new item can be accepted while a result waits on the output.
// The buffer takes a new item only after the buffered one has executed.
// An item that ends a frame also starts the check, which walks the stored
// bytes one read per cycle through the store's single read port; a good
// frame with payload then delivers one payload result per byte (read, then
// load the output register once it is free). The frame store is not
// cleared after reset, so the block is ready at once.
module serial_frame_receiver_unit
  import sfr_pkg::*;
#(
  parameter int FRAME_MAX   = 64,
  parameter int PAYLOAD_MAX = 59
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sfr_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sfr_out_t   out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  sfr_datapath #(
    .FRAME_MAX   (FRAME_MAX),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_exec_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> sts.buf_valid)
    else $error("item executed with empty buffer");

  a_one_load : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_evt, cmd.load_final, cmd.emit_load}))
    else $error("more than one output load at once");

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_evt || cmd.load_final || cmd.emit_load) |-> sts.out_free)
    else $error("output register overwritten");

  a_read_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_rd && (cmd.emit_rd || cmd.exec)))
    else $error("scan read overlaps another operation");

endmodule

// File: hw/rtl/sfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/sfr_datapath.sv
// Datapath of the serial frame receiver: config registers, input buffer,
// receive state, frame store, check captures and the output register.
// Depends on sfr_pkg and sfr_ram.
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int FRAME_MAX   = 64,
  parameter int PAYLOAD_MAX = 59
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sfr_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sfr_out_t   out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  sfr_cmd_t   cmd,
  output sfr_sts_t   sts
);

  localparam int AW = $clog2(FRAME_MAX);
  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam int XW = CW + 1;

  typedef enum logic [1:0] {MODE_IDLE, MODE_HUNT, MODE_COLLECT} mode_t;

  logic [7:0]  hdr_r, tail_r, gap_r;
  logic        buf_valid_r;
  sfr_in_t     buf_r;
  mode_t       mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] elapsed_r, elapsed_nxt, deadline_r, deadline_nxt, elapsed_inc;
  logic [7:0]  idle_r, idle_nxt, idle_inc;
  logic        expired;
  logic        evt_res, evt_check, wr_en;
  logic [2:0]  evt_code;
  logic [AW-1:0] wr_addr, rd_addr, ptr_r, rd_idx_r;
  logic        rd_vld_r;
  logic [7:0]  rdata;
  logic [7:0]  b0_r, b1_r, b2_r, sum_r, chk_r, tcap_r;
  logic [CW-1:0] k_r, plen_full;
  logic [XW-1:0] idx_x, cnt_x;
  logic        in_sum, is_chk, is_tail;
  logic        fmt_bad, too_long, cks_bad;
  logic [2:0]  final_code;
  logic        out_valid_r, out_load;
  sfr_out_t    out_r, out_nxt;

  sfr_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_store (
    .clk   (clk),
    .we    (cmd.exec & wr_en),
    .waddr (wr_addr),
    .wdata (buf_r.rx_byte),
    .re    (cmd.scan_rd | cmd.emit_rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign elapsed_inc = (elapsed_r != '1) ? elapsed_r + 32'd1 : elapsed_r;
  assign idle_inc    = (idle_r != '1) ? idle_r + 8'd1 : idle_r;
  assign expired     = (deadline_r != '1) && (elapsed_inc >= deadline_r);

  // Effect of the buffered item on the receive state
  always_comb begin
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    elapsed_nxt  = elapsed_r;
    deadline_nxt = deadline_r;
    idle_nxt     = idle_r;
    evt_res      = 1'b0;
    evt_code     = ST_OK;
    evt_check    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    unique case (buf_r.operation)
      OP_START: begin
        count_nxt    = '0;
        elapsed_nxt  = '0;
        idle_nxt     = '0;
        deadline_nxt = buf_r.limit_ticks;
        if (buf_r.limit_ticks == '0) begin
          evt_res  = 1'b1;
          evt_code = ST_BAD_ARG;
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_HUNT;
        end
      end
      OP_BYTE: begin
        if (mode_r != MODE_IDLE) begin
          if (buf_r.line_error) begin
            evt_res  = 1'b1;
            evt_code = ST_LINE_ERR;
            mode_nxt = MODE_IDLE;
          end else if (mode_r == MODE_HUNT) begin
            if (buf_r.rx_byte == hdr_r) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              count_nxt = CW'(1);
              idle_nxt  = '0;
              mode_nxt  = MODE_COLLECT;
            end
          end else if (count_r >= CW'(FRAME_MAX)) begin
            evt_check = 1'b1;
            mode_nxt  = MODE_IDLE;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            idle_nxt  = '0;
            // full store ends the frame at once
            if (count_r == CW'(FRAME_MAX - 1)) begin
              mode_nxt = MODE_IDLE;
              if (buf_r.rx_byte != tail_r) begin
                evt_res  = 1'b1;
                evt_code = ST_OVERFLOW;
              end else begin
                evt_check = 1'b1;
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (mode_r != MODE_IDLE) begin
          elapsed_nxt = elapsed_inc;
          if (mode_r == MODE_HUNT) begin
            if (expired) begin
              evt_res  = 1'b1;
              evt_code = ST_TIMEOUT;
              mode_nxt = MODE_IDLE;
            end
          end else begin
            idle_nxt = idle_inc;
            if (expired || (idle_inc >= gap_r)) begin
              evt_check = 1'b1;
              mode_nxt  = MODE_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Frame check decode from the captured bytes
  assign plen_full  = count_r - CW'(5);
  assign idx_x      = XW'(rd_idx_r);
  assign cnt_x      = XW'(count_r);
  assign in_sum     = (idx_x + XW'(2)) < cnt_x;
  assign is_chk     = (idx_x + XW'(2)) == cnt_x;
  assign is_tail    = (idx_x + XW'(1)) == cnt_x;
  assign fmt_bad    = (count_r < CW'(5)) || (b0_r != hdr_r) || (tcap_r != tail_r);
  assign too_long   = 32'(count_r) > (32'(PAYLOAD_MAX) + 32'd5);
  assign cks_bad    = chk_r != sum_r;
  assign final_code = fmt_bad ? ST_FORMAT : too_long ? ST_TOO_LONG :
                      cks_bad ? ST_CHECKSUM : ST_OK;

  assign rd_addr = cmd.emit_rd ? AW'(k_r + CW'(3)) : ptr_r;

  always_comb begin
    out_nxt      = '0;
    out_nxt.last = 1'b1;
    if (cmd.emit_load) begin
      out_nxt.status         = ST_OK;
      out_nxt.address        = b1_r;
      out_nxt.function_code  = b2_r;
      out_nxt.pay_len        = 6'(plen_full);
      out_nxt.payload_byte   = rdata;
      out_nxt.byte_index     = 6'(k_r);
      out_nxt.byte_valid     = 1'b1;
      out_nxt.last           = sts.emit_last;
    end else if (cmd.load_final) begin
      out_nxt.status = final_code;
      if (final_code == ST_OK) begin
        out_nxt.address       = b1_r;
        out_nxt.function_code = b2_r;
      end
    end else begin
      out_nxt.status = evt_code;
    end
  end

  assign out_load = cmd.load_evt | cmd.load_final | cmd.emit_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r       <= HEADER_RST;
      tail_r      <= TAIL_RST;
      gap_r       <= IDLE_GAP_RST;
      buf_valid_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      count_r     <= '0;
      elapsed_r   <= '0;
      deadline_r  <= '0;
      idle_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEADER:   hdr_r  <= cfg_wdata;
          CFG_TAIL:     tail_r <= cfg_wdata;
          CFG_IDLE_GAP: gap_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        buf_valid_r <= 1'b1;
      end else if (cmd.exec) begin
        buf_valid_r <= 1'b0;
      end
      if (cmd.exec) begin
        mode_r     <= mode_nxt;
        count_r    <= count_nxt;
        elapsed_r  <= elapsed_nxt;
        deadline_r <= deadline_nxt;
        idle_r     <= idle_nxt;
      end
      rd_vld_r <= cmd.scan_rd;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_r <= in_data;
    end
    if (cmd.exec) begin
      ptr_r <= '0;
      k_r   <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.scan_rd) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (cmd.emit_load) begin
        k_r <= k_r + CW'(1);
      end
      if (rd_vld_r && in_sum) begin
        sum_r <= sum_r + rdata;
      end
    end
    if (cmd.scan_rd) begin
      rd_idx_r <= ptr_r;
    end
    if (rd_vld_r) begin
      if (rd_idx_r == AW'(0)) b0_r <= rdata;
      if (rd_idx_r == AW'(1)) b1_r <= rdata;
      if (rd_idx_r == AW'(2)) b2_r <= rdata;
      if (is_chk)  chk_r  <= rdata;
      if (is_tail) tcap_r <= rdata;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign in_ready  = !buf_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.buf_valid   = buf_valid_r;
  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.evt_res     = evt_res;
  assign sts.evt_check   = evt_check;
  assign sts.ptr_last    = CW'(ptr_r) == (count_r - CW'(1));
  assign sts.final_multi = (final_code == ST_OK) && (plen_full != '0);
  assign sts.emit_last   = (k_r + CW'(1)) == plen_full;

endmodule

// File: hw/rtl/sfr_ctrl.sv
// Controller of the serial frame receiver: sequences item execution,
// the frame check scan and the payload run. Depends on sfr_pkg.
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sfr_sts_t sts,
  output sfr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_DECIDE, S_EMIT_RD, S_EMIT_WR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        // hold an item that gives a result until the output register frees
        cmd.exec     = sts.buf_valid && (sts.out_free || !sts.evt_res);
        cmd.load_evt = cmd.exec && sts.evt_res;
        if (cmd.exec && sts.evt_check) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.final_multi) begin
          state_nxt = S_EMIT_RD;
        end else if (sts.out_free) begin
          cmd.load_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
